### rtl/core/fti_pkg.sv
// shared constants, types and controller encoding for the fisher transform block
`default_nettype none
package fti_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SLOT_W     = $clog2(MAX_WINDOW);
	localparam int LEN_W      = SLOT_W + 1;
	localparam int MID_W      = 33;
	localparam int FISH_W     = 21;
	localparam int LEVEL_W    = 18;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

	localparam logic signed [LEVEL_W-1:0] COEF_NEW    = 18'sd43254;
	localparam logic signed [LEVEL_W-1:0] COEF_OLD    = 18'sd43909;
	localparam logic signed [21:0]        CLIP_THRESH = 22'sd64881;
	localparam logic signed [LEVEL_W-1:0] CLIP_VALUE  = 18'sd65470;
	localparam logic signed [61:0]        HALF_LN2    = 62'sd1488522236;
	localparam logic signed [25:0]        FISH_MAX    = 26'sd1048575;
	localparam logic signed [25:0]        FISH_MIN    = -26'sd1048576;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_SMOOTH,
		ST_LNORM_A,
		ST_LSQ_A,
		ST_LNORM_B,
		ST_LSQ_B,
		ST_ATANH,
		ST_FISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic write;
		logic scan;
		logic prep;
		logic div;
		logic mul;
		logic smooth;
		logic lnorm;
		logic lsq;
		logic log_sel;
		logic atanh;
		logic fish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic full_next;
		logic scan_done;
		logic full;
		logic div_last;
		logic log_last;
		logic out_free;
	} st_t;

endpackage
`default_nettype wire

### rtl/core/fti_ram.sv
// generic single write port ram with registered read
`default_nettype none
module fti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/fti_ctrl.sv
// sequencer for window update, rescan, divide, log and output steps
`default_nettype none
module fti_ctrl import fti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire st_t  st,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (st.need_scan) state_d = ST_SCAN;
				else if (st.full_next) state_d = ST_PREP;
				else state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (st.scan_done) state_d = st.full ? ST_PREP : ST_IDLE;
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (st.div_last) state_d = ST_MUL;
			end
			ST_MUL:     state_d = ST_SMOOTH;
			ST_SMOOTH:  state_d = ST_LNORM_A;
			ST_LNORM_A: state_d = ST_LSQ_A;
			ST_LSQ_A: begin
				if (st.log_last) state_d = ST_LNORM_B;
			end
			ST_LNORM_B: state_d = ST_LSQ_B;
			ST_LSQ_B: begin
				if (st.log_last) state_d = ST_ATANH;
			end
			ST_ATANH: state_d = ST_FISH;
			ST_FISH:  state_d = ST_OUT;
			ST_OUT: begin
				if (st.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_WRITE:  cmd.write  = 1'b1;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_PREP:   cmd.prep   = 1'b1;
			ST_DIV:    cmd.div    = 1'b1;
			ST_MUL:    cmd.mul    = 1'b1;
			ST_SMOOTH: cmd.smooth = 1'b1;
			ST_LNORM_A: cmd.lnorm = 1'b1;
			ST_LSQ_A:   cmd.lsq   = 1'b1;
			ST_LNORM_B: begin
				cmd.lnorm   = 1'b1;
				cmd.log_sel = 1'b1;
			end
			ST_LSQ_B: begin
				cmd.lsq     = 1'b1;
				cmd.log_sel = 1'b1;
			end
			ST_ATANH: cmd.atanh = 1'b1;
			ST_FISH:  cmd.fish  = 1'b1;
			ST_OUT:   cmd.emit  = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/fti_dp.sv
// window store, extreme tracking, serial divide, smoothing, log and fisher arithmetic
`default_nettype none
module fti_dp import fti_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [LEN_W-1:0]         cfg_data,
	input  wire logic [31:0]              in_high,
	input  wire logic [31:0]              in_low,
	input  wire logic                     in_start,
	input  wire cmd_t                     cmd,
	output st_t                           st,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [FISH_W-1:0]      out_fisher,
	output logic signed [FISH_W-1:0]      out_signal
);

	// configuration and series state
	logic [LEN_W-1:0]  wlen_q;
	logic [LEN_W-1:0]  len;
	logic [LEN_W-1:0]  bars_q;
	logic [SLOT_W-1:0] wslot_q;
	logic [MID_W-1:0]  hi_q, lo_q;
	logic [SLOT_W-1:0] hi_slot_q, lo_slot_q;
	logic              hi_ok_q, lo_ok_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [FISH_W-1:0]  last_f_q;
	logic              clr;

	// per bar working registers
	logic [MID_W-1:0]  mid_q;
	logic              need_hi_q, need_lo_q;
	logic [SLOT_W-1:0] scan_slot_q;
	logic [LEN_W-1:0]  scan_left_q;
	logic              scan_first_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	logic [MID_W-1:0]  rd_data;

	// write step
	logic [SLOT_W-1:0] w;
	logic              was_full;
	logic [LEN_W-1:0]  n;
	logic [LEN_W:0]    osum;
	logic [SLOT_W-1:0] oldest;
	logic [SLOT_W-1:0] w_next;
	logic [SLOT_W-1:0] scan_next;
	logic              need_hi, need_lo;

	always_comb begin
		if (wlen_q == '0) len = LEN_W'(1);
		else if (wlen_q > LEN_W'(MAX_WINDOW)) len = LEN_W'(MAX_WINDOW);
		else len = wlen_q;
		w        = ({1'b0, wslot_q} >= len) ? '0 : wslot_q;
		was_full = bars_q >= len;
		n        = was_full ? bars_q : bars_q + LEN_W'(1);
		osum     = {2'b0, w} + {1'b0, len} - {1'b0, n} + (LEN_W+1)'(1);
		oldest   = (osum >= {1'b0, len}) ? SLOT_W'(osum - {1'b0, len}) : osum[SLOT_W-1:0];
		w_next   = ({1'b0, w} + LEN_W'(1) == len) ? '0 : w + SLOT_W'(1);
		scan_next = ({1'b0, scan_slot_q} + LEN_W'(1) == len) ? '0
			: scan_slot_q + SLOT_W'(1);
		need_hi  = !hi_ok_q || (was_full && hi_slot_q == w);
		need_lo  = !lo_ok_q || (was_full && lo_slot_q == w);
	end

	assign clr = cfg_we || (cmd.load && in_start);

	fti_ram #(
		.WIDTH(MID_W),
		.DEPTH(MAX_WINDOW)
	) u_window (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(w),
		.wdata(mid_q),
		.raddr(scan_slot_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= LEN_RESET;
			bars_q    <= '0;
			wslot_q   <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			hi_slot_q <= '0;
			lo_slot_q <= '0;
			hi_ok_q   <= 1'b0;
			lo_ok_q   <= 1'b0;
			need_hi_q <= 1'b0;
			need_lo_q <= 1'b0;
			scan_slot_q  <= '0;
			scan_left_q  <= '0;
			scan_first_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_slot_s1   <= '0;
		end else begin
			if (cfg_we) begin
				wlen_q <= cfg_data;
			end
			if (clr) begin
				bars_q    <= '0;
				wslot_q   <= '0;
				hi_q      <= '0;
				lo_q      <= '0;
				hi_slot_q <= '0;
				lo_slot_q <= '0;
				hi_ok_q   <= 1'b0;
				lo_ok_q   <= 1'b0;
			end else if (cmd.write) begin
				bars_q    <= n;
				wslot_q   <= w_next;
				need_hi_q <= need_hi;
				need_lo_q <= need_lo;
				scan_slot_q  <= oldest;
				scan_left_q  <= n;
				scan_first_q <= 1'b1;
				hi_ok_q <= 1'b1;
				lo_ok_q <= 1'b1;
				if (!need_hi && mid_q >= hi_q) begin
					hi_q      <= mid_q;
					hi_slot_q <= w;
				end
				if (!need_lo && mid_q <= lo_q) begin
					lo_q      <= mid_q;
					lo_slot_q <= w;
				end
			end else if (cmd.scan) begin
				// one read issued per cycle, compared in the next cycle
				rd_vld_s1  <= scan_left_q != '0;
				rd_slot_s1 <= scan_slot_q;
				if (scan_left_q != '0) begin
					scan_slot_q <= scan_next;
					scan_left_q <= scan_left_q - LEN_W'(1);
				end
				if (rd_vld_s1) begin
					scan_first_q <= 1'b0;
					if (need_hi_q && (scan_first_q || rd_data >= hi_q)) begin
						hi_q      <= rd_data;
						hi_slot_q <= rd_slot_s1;
					end
					if (need_lo_q && (scan_first_q || rd_data <= lo_q)) begin
						lo_q      <= rd_data;
						lo_slot_q <= rd_slot_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mid_q <= {1'b0, in_high} + {1'b0, in_low};
		end
	end

	// serial restoring divide, one quotient bit per cycle
	logic [MID_W:0]    r_q;
	logic [MID_W-1:0]  range_q;
	logic              zero_q;
	logic [17:0]       q_q;
	logic [4:0]        div_cnt_q;
	logic              ge;
	logic [MID_W:0]    r_sub;

	always_comb begin
		ge    = r_q >= {1'b0, range_q};
		r_sub = ge ? r_q - {1'b0, range_q} : r_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			range_q   <= hi_q - lo_q;
			zero_q    <= hi_q == lo_q;
			r_q       <= {1'b0, mid_q - lo_q};
			q_q       <= '0;
			div_cnt_q <= 5'd17;
		end else if (cmd.div) begin
			r_q       <= {r_sub[MID_W-1:0], 1'b0};
			q_q       <= {q_q[16:0], ge};
			div_cnt_q <= div_cnt_q - 5'd1;
		end
	end

	// smoothing multiplies
	logic [18:0]                x_sum;
	logic signed [LEVEL_W-1:0]  xs;
	logic signed [35:0]         p1_q, p2_q;

	always_comb begin
		x_sum = {1'b0, q_q} + 19'd1;
		xs    = zero_q ? -18'sd32768 : $signed(x_sum[18:1]) - 18'sd32768;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_q <= 36'(COEF_NEW) * 36'(xs);
			p2_q <= 36'(COEF_OLD) * 36'(level_q);
		end
	end

	logic signed [36:0] t_sum;
	logic [36:0]        t_mag;
	logic [20:0]        t_rnd;
	logic signed [21:0] v_raw;
	logic signed [LEVEL_W-1:0] v_clip;

	always_comb begin
		t_sum = {p1_q[35], p1_q} + {p2_q[35], p2_q};
		t_mag = t_sum[36] ? 37'(-t_sum) : 37'(t_sum);
		t_rnd = 21'((t_mag + 37'd32768) >> 16);
		v_raw = t_sum[36] ? -$signed({1'b0, t_rnd}) : $signed({1'b0, t_rnd});
		if (v_raw >= CLIP_THRESH) v_clip = CLIP_VALUE;
		else if (v_raw <= -CLIP_THRESH) v_clip = -CLIP_VALUE;
		else v_clip = LEVEL_W'(v_raw);
	end

	// log2 by normalization and repeated squaring
	logic [17:0] lx;
	logic [4:0]  le;
	logic [30:0] lm_q;
	logic [4:0]  lexp_q;
	logic [23:0] lfrac_q;
	logic [4:0]  lcnt_q;
	logic [28:0] la_q;
	logic [61:0] sq;
	logic [31:0] sq_hi;

	function automatic logic [17:0] lx_sel(input logic sel, input logic signed [LEVEL_W-1:0] v);
		logic signed [18:0] s;
		s = sel ? 19'sh10000 - {v[LEVEL_W-1], v} : 19'sh10000 + {v[LEVEL_W-1], v};
		return s[17:0];
	endfunction

	always_comb begin
		lx = lx_sel(cmd.log_sel, level_q);
		le = '0;
		for (int i = 0; i < 18; i++) begin
			if (lx[i]) le = 5'(i);
		end
		sq    = {31'b0, lm_q} * {31'b0, lm_q};
		sq_hi = sq[61:30];
	end

	always_ff @(posedge clk) begin
		if (cmd.lnorm) begin
			if (cmd.log_sel) la_q <= {lexp_q, lfrac_q};
			lexp_q  <= le;
			lm_q    <= 31'({13'b0, lx} << (5'd30 - le));
			lfrac_q <= '0;
			lcnt_q  <= 5'd23;
		end else if (cmd.lsq) begin
			lm_q           <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
			lfrac_q[lcnt_q] <= sq_hi[31];
			lcnt_q         <= lcnt_q - 5'd1;
		end
	end

	// atanh product and fisher update
	logic signed [29:0] dl;
	logic signed [61:0] prod_q;
	logic [61:0]        pr_mag;
	logic [22:0]        pr_rnd;
	logic signed [24:0] f_sum;
	logic [24:0]        f_mag;
	logic [24:0]        f_rnd;
	logic signed [25:0] f_raw;
	logic signed [FISH_W-1:0] f_q;

	always_comb begin
		dl     = $signed({1'b0, la_q}) - $signed({1'b0, lexp_q, lfrac_q});
		pr_mag = prod_q[61] ? 62'(-prod_q) : 62'(prod_q);
		pr_rnd = 23'((pr_mag + (62'd1 << 38)) >> 39);
		f_sum  = (prod_q[61] ? -$signed({2'b0, pr_rnd}) : $signed({2'b0, pr_rnd}))
			+ 25'(last_f_q);
		f_mag  = f_sum[24] ? 25'(-f_sum) : 25'(f_sum);
		f_rnd  = (f_mag + 25'd1) >> 1;
		f_raw  = f_sum[24] ? -$signed({1'b0, f_rnd}) : $signed({1'b0, f_rnd});
	end

	always_ff @(posedge clk) begin
		if (cmd.atanh) begin
			prod_q <= 62'(dl) * HALF_LN2;
		end
		if (cmd.fish) begin
			if (f_raw > FISH_MAX) f_q <= FISH_W'(FISH_MAX);
			else if (f_raw < FISH_MIN) f_q <= FISH_W'(FISH_MIN);
			else f_q <= FISH_W'(f_raw);
		end
		if (cmd.emit) begin
			out_fisher <= f_q;
			out_signal <= last_f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			last_f_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (clr) begin
				level_q  <= '0;
				last_f_q <= '0;
			end else begin
				if (cmd.smooth) level_q <= v_clip;
				if (cmd.emit) last_f_q <= f_q;
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_comb begin
		st.need_scan = need_hi || need_lo;
		st.full_next = n >= len;
		st.scan_done = scan_left_q == '0 && !rd_vld_s1;
		st.full      = bars_q >= len;
		st.div_last  = div_cnt_q == '0;
		st.log_last  = lcnt_q == '0;
		st.out_free  = !out_valid || out_ready;
	end

	a_bars_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		bars_q <= len)
		else $error("bar count exceeds window length");

	a_slot_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |=> {1'b0, wslot_q} < len)
		else $error("write slot outside window");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && rd_vld_s1 |-> {1'b0, rd_slot_s1} < len)
		else $error("rescan read outside window");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwritten before taken");

endmodule
`default_nettype wire

### rtl/core/fisher_transform_indicator.sv
// top level of the fisher transform indicator
//
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        one bar: high, low, series start
// m_*       out  m_tvalid / m_tready        fisher value and signal value
// cfg       in   window_length_we           window length, clears series
//
// when an extreme ages out, or on the first bar after a clear, the window is
// rescanned through the single ram read port, one bar at a time.
// the 18 step divide and two 24 step squaring log passes make up most of a bar's work.
// a result waits in the output register while the next bar is accepted.
// arst_n clears control and series state; window length resets to 10.
`default_nettype none
module fisher_transform_indicator import fti_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              window_length_we,
	input  wire logic [LEN_W-1:0]  window_length,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [63:0]       s_tdata,   // high_price, low_price
	input  wire logic              s_tuser,   // series_start
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [47:0]            m_tdata    // fisher_value, signal_value, zero pad
);

	cmd_t cmd;
	st_t  st;
	logic signed [FISH_W-1:0] fisher, sig;

	fti_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.st      (st),
		.cmd     (cmd)
	);

	fti_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (window_length_we),
		.cfg_data  (window_length),
		.in_high   (s_tdata[31:0]),
		.in_low    (s_tdata[63:32]),
		.in_start  (s_tuser),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_fisher(fisher),
		.out_signal(sig)
	);

	assign m_tdata = {6'b0, sig, fisher};

endmodule
`default_nettype wire
